[sv/cc3_pkg.sv]
// Package for the circumcentre block: output width, status codes and the
// side-band record that travels with each item along the divider chain.
// No dependencies.
`timescale 1ns / 1ps

package cc3_pkg;

    // Width of each output coordinate in fixed point.
    localparam int OUT_W = 48;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_COLLINEAR = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // Control and sign flags that accompany an item through the chain.
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic coll;
    } t_side;

endpackage

[sv/cc3_if.sv]
// Stream interfaces for the circumcentre block: the point triple input
// channel and the centre result channel. Depends on cc3_pkg.
`timescale 1ns / 1ps

interface cc3_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;

    modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface cc3_out_if;
    import cc3_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [1:0]              status;

    modport source (output valid, center_x, center_y, status, input ready);
    modport sink   (input valid, center_x, center_y, status, output ready);
endinterface

[sv/cc3_cell.sv]
// One restoring division step for both centre coordinates, registered.
// A chain of these cells forms the two dividers. Depends on cc3_pkg.
`timescale 1ns / 1ps

module cc3_cell #(
    parameter int NS  = 69,
    parameter int DEN = 36
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  cc3_pkg::t_side       i_side,
    input  logic [DEN-1:0]       i_den,
    input  logic [NS-1:0]        i_num_x,
    input  logic [NS-1:0]        i_num_y,
    input  logic [DEN-1:0]       i_rem_x,
    input  logic [DEN-1:0]       i_rem_y,
    input  logic [cc3_pkg::OUT_W-1:0] i_quo_x,
    input  logic [cc3_pkg::OUT_W-1:0] i_quo_y,
    input  logic                 i_stk_x,
    input  logic                 i_stk_y,
    output cc3_pkg::t_side       o_side,
    output logic [DEN-1:0]       o_den,
    output logic [NS-1:0]        o_num_x,
    output logic [NS-1:0]        o_num_y,
    output logic [DEN-1:0]       o_rem_x,
    output logic [DEN-1:0]       o_rem_y,
    output logic [cc3_pkg::OUT_W-1:0] o_quo_x,
    output logic [cc3_pkg::OUT_W-1:0] o_quo_y,
    output logic                 o_stk_x,
    output logic                 o_stk_y
);
    import cc3_pkg::*;

    logic [DEN:0]   w_tx, w_ty;
    logic           w_gex, w_gey;
    logic [DEN-1:0] n_rem_x, n_rem_y;

    // Bring down the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        w_tx    = {i_rem_x, i_num_x[NS-1]};
        w_ty    = {i_rem_y, i_num_y[NS-1]};
        w_gex   = (w_tx >= {1'b0, i_den});
        w_gey   = (w_ty >= {1'b0, i_den});
        n_rem_x = w_gex ? DEN'(w_tx - {1'b0, i_den}) : DEN'(w_tx);
        n_rem_y = w_gey ? DEN'(w_ty - {1'b0, i_den}) : DEN'(w_ty);
    end

    // Valid flag is reset; the payload is only loaded when the chain moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side.valid <= 1'b0;
        end else if (i_en) begin
            o_side.valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side.neg_x <= i_side.neg_x;
            o_side.neg_y <= i_side.neg_y;
            o_side.coll  <= i_side.coll;
            o_den        <= i_den;
            o_num_x      <= i_num_x << 1;
            o_num_y      <= i_num_y << 1;
            o_rem_x      <= n_rem_x;
            o_rem_y      <= n_rem_y;
            o_quo_x      <= {i_quo_x[OUT_W-2:0], w_gex};
            o_quo_y      <= {i_quo_y[OUT_W-2:0], w_gey};
            // A quotient bit leaving the window means the result saturates.
            o_stk_x      <= i_stk_x | i_quo_x[OUT_W-1];
            o_stk_y      <= i_stk_y | i_quo_y[OUT_W-1];
        end
    end

endmodule

[sv/circumcenter_from_three_points.sv]
// Circumcentre of three integer points: seven arithmetic stages, then a
// chain of 3*COORD_WIDTH+5+FRAC_BITS division cells, then an output stage.
// The divider chain yields one quotient bit per cell; one transfer is
// accepted every cycle while the output is not held.
// The whole pipeline stalls together when the output is held.
// Reset is synchronous and active low and clears only the valid flags.
`timescale 1ns / 1ps

module circumcenter_from_three_points #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cc3_in_if.sink     i_pt,
    cc3_out_if.source  o_cc
);
    import cc3_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int W1  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int CW  = 2 * W + 3;
    localparam int LW  = (CW + 1) / 2;
    localparam int HW  = CW - LW;
    localparam int PLW = W1 + LW + 1;
    localparam int PHW = W1 + HW;
    localparam int NW  = 3 * W + 5;
    localparam int NS  = NW + FRAC_BITS;
    localparam int DEN = 2 * W + 4;

    logic w_en;

    // Stage A: differences and doubled midpoints.
    logic              r_va;
    logic signed [W1-1:0] r_a1, r_b1, r_a2, r_b2, r_s1x, r_s1y, r_s2x, r_s2y;
    // Stage B: coefficient products.
    logic              r_vb;
    logic signed [W1-1:0] r_ba1, r_bb1, r_ba2, r_bb2;
    logic signed [PW-1:0] r_p1x, r_p1y, r_p2x, r_p2y, r_pd1, r_pd2;
    // Stage C: line constants and determinant.
    logic              r_vc;
    logic signed [W1-1:0] r_ca1, r_cb1, r_ca2, r_cb2;
    logic signed [CW-1:0] r_c1, r_c2, r_cdet;
    // Stage D: partial products of the Cramer numerators.
    logic              r_vd;
    logic signed [CW-1:0]  r_ddet;
    logic signed [PLW-1:0] r_lx1, r_lx2, r_ly1, r_ly2;
    logic signed [PHW-1:0] r_hx1, r_hx2, r_hy1, r_hy2;
    // Stage E: full products.
    logic              r_ve;
    logic signed [CW-1:0] r_edet;
    logic signed [NW-1:0] r_px1, r_px2, r_py1, r_py2;
    // Stage F: numerators.
    logic              r_vf;
    logic signed [CW-1:0] r_fdet;
    logic signed [NW-1:0] r_numx, r_numy;
    // Stage G: magnitudes and signs, loaded into the head of the chain.
    t_side             r_gside;
    logic [DEN-1:0]    r_gden;
    logic [NW-1:0]     r_magx, r_magy;

    logic signed [DEN-1:0] w_den2;

    // Chain taps.
    t_side           c_side [0:NS];
    logic [DEN-1:0]  c_den  [0:NS];
    logic [NS-1:0]   c_numx [0:NS];
    logic [NS-1:0]   c_numy [0:NS];
    logic [DEN-1:0]  c_remx [0:NS];
    logic [DEN-1:0]  c_remy [0:NS];
    logic [OUT_W-1:0] c_quox [0:NS];
    logic [OUT_W-1:0] c_quoy [0:NS];
    logic            c_stkx [0:NS];
    logic            c_stky [0:NS];

    // Output stage.
    logic              r_ov;
    logic [OUT_W-1:0]  r_ox, r_oy;
    logic [1:0]        r_ost;
    logic [OUT_W-1:0]  n_ox, n_oy;
    logic              w_satx, w_saty;

    // The whole pipeline advances unless a finished result is held.
    assign w_en       = !r_ov || o_cc.ready;
    assign i_pt.ready = w_en;

    // Valid flags of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_gside.valid <= 1'b0;
        end else if (w_en) begin
            r_va <= i_pt.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_gside.valid <= r_vf;
        end
    end

    assign w_den2 = {r_fdet, 1'b0};

    // Arithmetic stages A to G.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1  <= W1'(i_pt.bx) - W1'(i_pt.ax);
            r_b1  <= W1'(i_pt.by) - W1'(i_pt.ay);
            r_a2  <= W1'(i_pt.cx) - W1'(i_pt.bx);
            r_b2  <= W1'(i_pt.cy) - W1'(i_pt.by);
            r_s1x <= W1'(i_pt.ax) + W1'(i_pt.bx);
            r_s1y <= W1'(i_pt.ay) + W1'(i_pt.by);
            r_s2x <= W1'(i_pt.bx) + W1'(i_pt.cx);
            r_s2y <= W1'(i_pt.by) + W1'(i_pt.cy);

            r_ba1 <= r_a1;
            r_bb1 <= r_b1;
            r_ba2 <= r_a2;
            r_bb2 <= r_b2;
            r_p1x <= r_a1 * r_s1x;
            r_p1y <= r_b1 * r_s1y;
            r_p2x <= r_a2 * r_s2x;
            r_p2y <= r_b2 * r_s2y;
            r_pd1 <= r_a1 * r_b2;
            r_pd2 <= r_a2 * r_b1;

            r_ca1  <= r_ba1;
            r_cb1  <= r_bb1;
            r_ca2  <= r_ba2;
            r_cb2  <= r_bb2;
            r_c1   <= CW'(r_p1x) + CW'(r_p1y);
            r_c2   <= CW'(r_p2x) + CW'(r_p2y);
            r_cdet <= CW'(r_pd1) - CW'(r_pd2);

            // Each wide constant is split into an unsigned low and a signed high half.
            r_ddet <= r_cdet;
            r_lx1  <= r_cb2 * $signed({1'b0, r_c1[LW-1:0]});
            r_hx1  <= r_cb2 * $signed(r_c1[CW-1:LW]);
            r_lx2  <= r_cb1 * $signed({1'b0, r_c2[LW-1:0]});
            r_hx2  <= r_cb1 * $signed(r_c2[CW-1:LW]);
            r_ly1  <= r_ca1 * $signed({1'b0, r_c2[LW-1:0]});
            r_hy1  <= r_ca1 * $signed(r_c2[CW-1:LW]);
            r_ly2  <= r_ca2 * $signed({1'b0, r_c1[LW-1:0]});
            r_hy2  <= r_ca2 * $signed(r_c1[CW-1:LW]);

            r_edet <= r_ddet;
            r_px1  <= (NW'(r_hx1) <<< LW) + NW'(r_lx1);
            r_px2  <= (NW'(r_hx2) <<< LW) + NW'(r_lx2);
            r_py1  <= (NW'(r_hy1) <<< LW) + NW'(r_ly1);
            r_py2  <= (NW'(r_hy2) <<< LW) + NW'(r_ly2);

            r_fdet <= r_edet;
            r_numx <= r_px1 - r_px2;
            r_numy <= r_py1 - r_py2;

            r_gside.neg_x <= r_numx[NW-1] ^ r_fdet[CW-1];
            r_gside.neg_y <= r_numy[NW-1] ^ r_fdet[CW-1];
            r_gside.coll  <= (r_fdet == '0);
            r_gden <= w_den2[DEN-1] ? DEN'(-w_den2) : DEN'(w_den2);
            r_magx <= r_numx[NW-1] ? NW'(-r_numx) : NW'(r_numx);
            r_magy <= r_numy[NW-1] ? NW'(-r_numy) : NW'(r_numy);
        end
    end

    // Head of the divider chain: numerator magnitudes scaled by the fraction.
    assign c_side[0] = r_gside;
    assign c_den[0]  = r_gden;
    assign c_numx[0] = NS'(r_magx) << FRAC_BITS;
    assign c_numy[0] = NS'(r_magy) << FRAC_BITS;
    assign c_remx[0] = '0;
    assign c_remy[0] = '0;
    assign c_quox[0] = '0;
    assign c_quoy[0] = '0;
    assign c_stkx[0] = 1'b0;
    assign c_stky[0] = 1'b0;

    // One cell per quotient bit.
    for (genvar k = 0; k < NS; k++) begin : g_cell
        cc3_cell #(
            .NS  (NS),
            .DEN (DEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (c_side[k]),
            .i_den   (c_den[k]),
            .i_num_x (c_numx[k]),
            .i_num_y (c_numy[k]),
            .i_rem_x (c_remx[k]),
            .i_rem_y (c_remy[k]),
            .i_quo_x (c_quox[k]),
            .i_quo_y (c_quoy[k]),
            .i_stk_x (c_stkx[k]),
            .i_stk_y (c_stky[k]),
            .o_side  (c_side[k+1]),
            .o_den   (c_den[k+1]),
            .o_num_x (c_numx[k+1]),
            .o_num_y (c_numy[k+1]),
            .o_rem_x (c_remx[k+1]),
            .o_rem_y (c_remy[k+1]),
            .o_quo_x (c_quox[k+1]),
            .o_quo_y (c_quoy[k+1]),
            .o_stk_x (c_stkx[k+1]),
            .o_stk_y (c_stky[k+1])
        );
    end

    // Saturate a quotient magnitude and apply its sign.
    function automatic logic [OUT_W:0] fix_out(input logic [OUT_W-1:0] q,
                                               input logic stk, input logic neg);
        logic [OUT_W:0]   lim;
        logic             sat;
        logic [OUT_W-1:0] v;
        lim = neg ? (OUT_W+1)'(1) << (OUT_W-1) : ((OUT_W+1)'(1) << (OUT_W-1)) - 1'b1;
        sat = stk || ({1'b0, q} > lim);
        v   = sat ? lim[OUT_W-1:0] : q;
        return {sat, neg ? OUT_W'(-v) : v};
    endfunction

    always_comb begin
        {w_satx, n_ox} = fix_out(c_quox[NS], c_stkx[NS], c_side[NS].neg_x);
        {w_saty, n_oy} = fix_out(c_quoy[NS], c_stky[NS], c_side[NS].neg_y);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= c_side[NS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (c_side[NS].coll) begin
                r_ox  <= '0;
                r_oy  <= '0;
                r_ost <= STATUS_COLLINEAR;
            end else begin
                r_ox  <= n_ox;
                r_oy  <= n_oy;
                r_ost <= (w_satx || w_saty) ? STATUS_OVERFLOW : STATUS_OK;
            end
        end
    end

    assign o_cc.valid    = r_ov;
    assign o_cc.center_x = r_ox;
    assign o_cc.center_y = r_oy;
    assign o_cc.status   = r_ost;

endmodule

[test/tb.sv]
// Self-checking testbench for circumcenter_from_three_points: drives point
// triples, predicts each centre in wide integer arithmetic and checks it.
// Depends on cc3_pkg, cc3_if.sv and the block itself.
`timescale 1ns / 1ps

module tb;
    import cc3_pkg::*;

    localparam int CW        = 16;
    localparam int FB        = 16;
    localparam int N_RANDOM  = 1700;
    localparam int LIMIT     = 600000;
    localparam int TAIL      = 3 * CW + FB + 13 + 50;

    typedef logic signed [CW-1:0]    t_coord;
    typedef logic signed [OUT_W-1:0] t_out;
    typedef logic signed [127:0]     t_wide;

    typedef struct {
        t_out       cx;
        t_out       cy;
        logic [1:0] status;
    } t_centre;

    // Holds the predicted centres in order and compares results with them.
    class centre_board;
        t_centre pending[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // Saturates a scaled quotient to the output range.
        function t_out clamp(t_wide q, ref bit sat);
            t_wide hi_lim;
            t_wide lo_lim;
            hi_lim = (t_wide'(1) <<< (OUT_W - 1)) - 1;
            lo_lim = -(t_wide'(1) <<< (OUT_W - 1));
            if (q > hi_lim) begin
                sat = 1'b1;
                return hi_lim[OUT_W-1:0];
            end
            if (q < lo_lim) begin
                sat = 1'b1;
                return lo_lim[OUT_W-1:0];
            end
            return q[OUT_W-1:0];
        endfunction

        // Works out the centre of an accepted triple and queues it.
        function void note_triple(t_coord ax, t_coord ay, t_coord bx,
                                  t_coord by, t_coord cx, t_coord cy);
            longint  a1, b1, a2, b2, c1, c2, det;
            t_wide   num_x, num_y, den;
            bit      sat;
            t_centre e;
            a1  = longint'(bx) - longint'(ax);
            b1  = longint'(by) - longint'(ay);
            a2  = longint'(cx) - longint'(bx);
            b2  = longint'(cy) - longint'(by);
            c1  = a1 * (longint'(ax) + longint'(bx)) + b1 * (longint'(ay) + longint'(by));
            c2  = a2 * (longint'(bx) + longint'(cx)) + b2 * (longint'(by) + longint'(cy));
            det = a1 * b2 - a2 * b1;
            sat = 1'b0;
            if (det == 0) begin
                e.cx     = '0;
                e.cy     = '0;
                e.status = STATUS_COLLINEAR;
            end else begin
                num_x = t_wide'(b2) * t_wide'(c1) - t_wide'(b1) * t_wide'(c2);
                num_y = t_wide'(a1) * t_wide'(c2) - t_wide'(a2) * t_wide'(c1);
                den   = t_wide'(det) * 2;
                e.cx  = clamp((num_x <<< FB) / den, sat);
                e.cy  = clamp((num_y <<< FB) / den, sat);
                e.status = sat ? STATUS_OVERFLOW : STATUS_OK;
            end
            pending.push_back(e);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_centre(t_out cx, t_out cy, logic [1:0] status);
            t_centre e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d status=%0d",
                         $time, cx, cy, status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (cx !== e.cx) begin
                $display("%0t: centre_x expected %0d actual %0d", $time, e.cx, cx);
                errors++;
            end
            if (cy !== e.cy) begin
                $display("%0t: centre_y expected %0d actual %0d", $time, e.cy, cy);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   accepted;

    cc3_in_if #(.COORD_WIDTH(CW)) pt_if ();
    cc3_out_if                    cc_if ();

    centre_board board;

    circumcenter_from_three_points #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .o_cc    (cc_if.source)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Known values on every input from time zero.
    initial begin
        board        = new();
        accepted     = 0;
        i_rst_n      = 1'b0;
        pt_if.valid  = 1'b0;
        pt_if.ax     = '0;
        pt_if.ay     = '0;
        pt_if.bx     = '0;
        pt_if.by     = '0;
        pt_if.cx     = '0;
        pt_if.cy     = '0;
        cc_if.ready  = 1'b0;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end
    initial cycles = 0;

    // Offers one triple and waits for its transfer; an optional gap follows.
    task automatic send_triple(t_coord ax, t_coord ay, t_coord bx,
                               t_coord by, t_coord cx, t_coord cy, int gap);
        pt_if.valid <= 1'b1;
        pt_if.ax    <= ax;
        pt_if.ay    <= ay;
        pt_if.bx    <= bx;
        pt_if.by    <= by;
        pt_if.cx    <= cx;
        pt_if.cy    <= cy;
        do @(posedge i_clk); while (!pt_if.ready);
        board.note_triple(ax, ay, bx, by, cx, cy);
        accepted++;
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls, stretches of steady ready and one long hold.
    int  hold_left  = 0;
    int  calm_left  = 0;
    bit  hold_done  = 0;
    always @(posedge i_clk) begin
        if (cc_if.valid && cc_if.ready && i_rst_n)
            board.check_centre(cc_if.center_x, cc_if.center_y, cc_if.status);
        if (!i_rst_n) begin
            cc_if.ready <= 1'b0;
        end else if (!hold_done && accepted >= 400) begin
            hold_done = 1;
            hold_left = 400;
            cc_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            cc_if.ready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            cc_if.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 15) == 0)
                calm_left = $urandom_range(10, 60);
            cc_if.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Stimulus and end of run.
    initial begin : stim
        t_coord p[6];
        int     burst;
        int     gap;
        int     kind;
        int     k;
        int     waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, coincident points, collinear points, overflow.
        send_triple(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 0);
        send_triple(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
        send_triple(0, 0, 0, 0, 0, 0, 0);
        send_triple(1, 1, 1, 1, 5, -3, 0);
        send_triple(0, 0, 1, 1, 2, 2, 2);
        send_triple(16'sh8000, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh7FFF, 0);
        send_triple(16'sh8000, 16'sh8001, 16'sh7FFF, 16'sh7FFF, 0, 0, 0);
        send_triple(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFE, 0, 0, 0);
        send_triple(16'sh8000, 0, 16'sh7FFF, 1, 16'sh7FFE, 0, 3);
        send_triple(0, 0, 4, 0, 0, 4, 0);
        send_triple(0, 0, 1, 0, 0, 1, 0);
        send_triple(-1, -1, 1, -1, 0, 1, 0);
        send_triple(16'sh7FFF, 0, 0, 16'sh7FFF, 16'sh8000, 0, 0);
        send_triple(0, 16'sh8000, 16'sh7FFF, 0, 0, 16'sh7FFF, 0);
        send_triple(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 1);
        send_triple(16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0000, 16'sh1234, 16'shEDCB, 0);

        // Random: full range, small coordinates and nearly collinear triples.
        k = 0;
        while (k < N_RANDOM) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && k < N_RANDOM; b++) begin
                kind = $urandom_range(0, 9);
                for (int j = 0; j < 6; j++) begin
                    if (kind < 4)
                        p[j] = t_coord'($urandom());
                    else
                        p[j] = t_coord'($signed($urandom_range(0, 64)) - 32);
                end
                if (kind >= 7) begin
                    // C lies on or just beside the line through A and B.
                    int sx;
                    int sy;
                    sx = $urandom_range(0, 1) ? 1 : -1;
                    sy = $urandom_range(0, 1) ? 1 : -1;
                    p[0] = t_coord'(sx * int'($urandom_range(0, 32767)));
                    p[1] = t_coord'(sy * int'($urandom_range(0, 32767)));
                    p[2] = -p[0];
                    p[3] = -p[1];
                    p[4] = t_coord'((kind == 9 ? 0 : $signed($urandom_range(0, 2)) - 1));
                    p[5] = t_coord'($signed($urandom_range(0, 2)) - 1);
                end
                gap = (b == burst - 1) ? $urandom_range(1, 6) : 0;
                send_triple(p[0], p[1], p[2], p[3], p[4], p[5], gap);
                k++;
            end
        end
        pt_if.valid <= 1'b0;

        // Drain, then let the pipeline settle.
        waited = 0;
        while (board.pending.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
